// File: rtl/dfr_pkg.sv
package dfr_pkg;

	localparam int unsigned FRAME_MAX   = 64;
	localparam int unsigned STORE_DEPTH = FRAME_MAX;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned LEN_W       = ADDR_W + 1;
	localparam int unsigned COUNT_W     = 32;

	// '$' fits while the length is below END_LIMIT, a data byte below DATA_LIMIT
	localparam logic [LEN_W-1:0] END_LIMIT  = LEN_W'(FRAME_MAX - 1);
	localparam logic [LEN_W-1:0] DATA_LIMIT = LEN_W'(FRAME_MAX - 2);

	localparam logic [7:0] CH_START = 8'h23;
	localparam logic [7:0] CH_END   = 8'h24;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;

	function automatic logic is_kept(input logic [7:0] c);
		logic kept;
		kept = c inside {[PRINT_LO:PRINT_HI], CH_CR, CH_LF, CH_TAB};
		return kept;
	endfunction

endpackage

// File: rtl/dfr_ram.sv
module dfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/delimited_frame_receiver_top.sv
// Bytes that emit nothing leave in_ready high, so the next byte can be taken straight after.
// An error report is valid in the cycle after the offending byte's transfer.
// After the closing '$' the first frame byte goes through ST_READ (one store read)
// and ST_LOAD and is valid in ST_SEND; each following byte does so after the previous transfer.
// Reset clears length, bad count and control; the store is not cleared and holds
// garbage until written.
module delimited_frame_receiver_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            frame_byte,
	output logic                  last_of_frame,
	output logic                  error_report,
	output logic [31:0]           bad_frame_count
);
	import dfr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_SEND = 2'd3;

	logic [1:0] state_q;
	len_t       len_q;
	len_t       ptr_q;
	len_t       end_q;
	count_t     bad_q;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       err_q;
	count_t     cnt_q;

	logic       wr_en;
	addr_t      wr_addr;
	logic [7:0] wr_data;
	logic       rd_en;
	logic [7:0] rd_data;

	logic       take;
	logic       is_start;
	logic       is_end;
	logic       end_ok;
	logic       data_ok;
	logic       go_bad;
	logic       go_emit;
	len_t       ptr_next;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign is_start = (rx_byte == CH_START);
	assign is_end   = (rx_byte == CH_END);
	assign end_ok   = (len_q < END_LIMIT);
	assign data_ok  = (len_q < DATA_LIMIT);
	assign ptr_next = ptr_q + len_t'(1);

	assign go_emit = take && !is_start && (len_q != '0) && is_end && end_ok;
	assign go_bad  = take && !is_start && (len_q != '0) &&
		((is_end && !end_ok) || (!is_end && is_kept(rx_byte) && !data_ok));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rx_byte;
		if (take) begin
			if (is_start) begin
				wr_en = 1'b1;
			end else if (go_emit) begin
				wr_en   = 1'b1;
				wr_addr = len_q[ADDR_W-1:0];
			end else if (len_q != '0 && !is_end && is_kept(rx_byte) && data_ok) begin
				wr_en   = 1'b1;
				wr_addr = len_q[ADDR_W-1:0];
			end
		end
	end

	assign rd_en = (state_q == ST_READ);

	dfr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(ptr_q[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			ptr_q       <= '0;
			end_q       <= '0;
			bad_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (is_start) begin
							len_q <= len_t'(1);
						end else if (go_emit) begin
							end_q   <= len_q + len_t'(1);
							ptr_q   <= '0;
							len_q   <= '0;
							state_q <= ST_READ;
						end else if (go_bad) begin
							bad_q       <= bad_q + count_t'(1);
							len_q       <= '0;
							out_valid_q <= 1'b1;
							state_q     <= ST_SEND;
						end else if (wr_en) begin
							len_q <= len_q + len_t'(1);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					ptr_q       <= ptr_next;
					out_valid_q <= 1'b1;
					state_q     <= ST_SEND;
				end
				ST_SEND: begin
					// hold the result until the transfer, then fetch the next byte unless it was the last or an error
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= (err_q || last_q) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go_bad) begin
			byte_q <= '0;
			last_q <= 1'b0;
			err_q  <= 1'b1;
			cnt_q  <= bad_q + count_t'(1);
		end else if (state_q == ST_LOAD) begin
			byte_q <= rd_data;
			last_q <= (ptr_next == end_q);
			err_q  <= 1'b0;
			cnt_q  <= bad_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_byte      = byte_q;
	assign last_of_frame   = last_q;
	assign error_report    = err_q;
	assign bad_frame_count = cnt_q;

endmodule

// File: rtl/dfr_checker.sv
module dfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  frame_byte,
	input logic        last_of_frame,
	input logic        error_report,
	input logic [31:0] bad_frame_count
);
	import dfr_pkg::*;

	// one item at a time: no input transfer while a result is pending
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && rx_byte == CH_START |=> !out_valid)
		else $error("start byte produced a result");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_report |-> frame_byte == 8'h00 && !last_of_frame)
		else $error("error report with frame data");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_frame |-> frame_byte == CH_END)
		else $error("last byte of frame is not the end delimiter");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) &&
			$stable(last_of_frame) && $stable(error_report) && $stable(bad_frame_count))
		else $error("stalled result changed");

endmodule

bind delimited_frame_receiver_top dfr_checker u_dfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.rx_byte        (rx_byte),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.frame_byte     (frame_byte),
	.last_of_frame  (last_of_frame),
	.error_report   (error_report),
	.bad_frame_count(bad_frame_count)
);

// File: test/tb_delimited_frame_receiver_top.sv
module tb_delimited_frame_receiver_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dfr_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 220;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       err;
		count_t     count;
	} frame_out_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_byte;
	logic        last_of_frame;
	logic        error_report;
	logic [31:0] bad_frame_count;

	// model of the receiver: bytes of the open frame, its length, discard count
	logic [7:0]  held_bytes [FRAME_MAX];
	int          held_len = 0;
	count_t      discard_count = '0;
	frame_out_t  frame_out_q[$];

	int          fail_count = 0;
	int          items_sent = 0;
	int          receiver_stall_left = 0;
	bit          no_idle = 1'b0;

	delimited_frame_receiver_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_byte      (frame_byte),
		.last_of_frame   (last_of_frame),
		.error_report    (error_report),
		.bad_frame_count (bad_frame_count)
	);

	always #6 clk = ~clk;

	function automatic void push_discard();
		frame_out_t r;
		discard_count = discard_count + 1;
		held_len = 0;
		r.data = 8'h00;
		r.last = 1'b0;
		r.err = 1'b1;
		r.count = discard_count;
		frame_out_q.push_back(r);
	endfunction

	function automatic void predict_frame_out(input logic [7:0] c);
		frame_out_t r;
		bit kept;
		kept = (c >= PRINT_LO && c <= PRINT_HI) || c == CH_CR || c == CH_LF || c == CH_TAB;
		if (c == CH_START) begin
			held_bytes[0] = CH_START;
			held_len = 1;
		end else if (held_len == 0) begin
			// idle: wait for a start
		end else if (c == CH_END) begin
			if (held_len + 1 < FRAME_MAX) begin
				held_bytes[held_len] = CH_END;
				held_len++;
				for (int i = 0; i < held_len; i++) begin
					r.data = held_bytes[i];
					r.last = (i == held_len - 1);
					r.err = 1'b0;
					r.count = discard_count;
					frame_out_q.push_back(r);
				end
				held_len = 0;
			end else begin
				push_discard();
			end
		end else if (kept) begin
			if (held_len + 2 >= FRAME_MAX) begin
				push_discard();
			end else begin
				held_bytes[held_len] = c;
				held_len++;
			end
		end
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// check every result transfer against the oldest prediction
	always @(posedge clk) begin
		frame_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_out_q.size() == 0) begin
				note_failure($sformatf("unexpected result byte=%02h last=%0b err=%0b count=%0d",
					frame_byte, last_of_frame, error_report, bad_frame_count));
			end else begin
				want = frame_out_q.pop_front();
				if (frame_byte !== want.data || last_of_frame !== want.last ||
						error_report !== want.err || bad_frame_count !== want.count)
					note_failure($sformatf({"mismatch: expected byte=%02h last=%0b err=%0b ",
						"count=%0d, got byte=%02h last=%0b err=%0b count=%0d"},
						want.data, want.last, want.err, want.count,
						frame_byte, last_of_frame, error_report, bad_frame_count));
			end
		end
	end

	// receiver side: random stalls, a counted hold-off when requested, or always ready under no_idle
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_stall_left > 0) begin
				out_ready <= 1'b0;
				receiver_stall_left--;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 33);
			end
		end
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		predict_frame_out(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (frame_out_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] body_byte();
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			case ($urandom_range(0, 2))
				0: c = CH_CR;
				1: c = CH_LF;
				default: c = CH_TAB;
			endcase
		end else if (pick < 14) begin
			// noise: control bytes and the upper half
			do
				c = 8'($urandom);
			while ((c >= PRINT_LO && c <= PRINT_HI) || c == CH_CR || c == CH_LF ||
				c == CH_TAB);
		end else begin
			do
				c = 8'($urandom_range(PRINT_LO, PRINT_HI));
			while (c == CH_START || c == CH_END);
		end
		return c;
	endfunction

	task automatic send_body(input int n);
		for (int i = 0; i < n; i++)
			send_byte(body_byte());
	endtask

	task automatic send_frame(input int n);
		send_byte(CH_START);
		send_body(n);
		send_byte(CH_END);
	endtask

	task automatic test_basics();
		// empty frame
		send_byte(CH_START);
		send_byte(CH_END);
		// bytes outside a frame are ignored
		send_byte(CH_END);
		send_byte(8'h41);
		send_byte(8'h00);
		send_byte(8'hFF);
		// kept extremes and whitespace
		send_byte(CH_START);
		send_byte(PRINT_LO);
		send_byte(PRINT_HI);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_TAB);
		send_byte(CH_END);
		// noise inside a frame is dropped
		send_byte(CH_START);
		send_byte(8'h00);
		send_byte(8'h1F);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(CH_END);
		// a start in the middle restarts the frame
		send_byte(CH_START);
		send_byte(8'h41);
		send_byte(CH_START);
		send_byte(8'h42);
		send_byte(CH_END);
		wait_drained();
	endtask

	task automatic test_length_limits();
		// longest frame that still fits
		send_byte(CH_START);
		for (int i = 1; i < FRAME_MAX - 2; i++)
			send_byte(8'($urandom_range(8'h41, 8'h5A)));
		send_byte(CH_END);
		wait_drained();
		// one data byte too many
		send_byte(CH_START);
		for (int i = 1; i < FRAME_MAX - 2; i++)
			send_byte(8'($urandom_range(8'h61, 8'h7A)));
		send_byte(8'h2E);
		send_byte(CH_END);
		// noise at the limit does not overflow
		send_byte(CH_START);
		for (int i = 1; i < FRAME_MAX - 2; i++)
			send_byte(8'h30);
		send_byte(8'h7F);
		send_byte(CH_END);
		wait_drained();
	endtask

	task automatic test_back_pressure();
		no_idle = 1'b1;
		receiver_stall_left = 300;
		for (int i = 0; i < 8; i++)
			send_frame($urandom_range(0, 12));
		no_idle = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_frames();
		int goal;
		int kind;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			no_idle = (goal - items_sent) inside {[80:180]};
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				send_frame($urandom_range(0, 16));
			end else if (kind < 66) begin
				send_frame($urandom_range(40, FRAME_MAX - 3));
			end else if (kind < 72) begin
				send_byte(CH_START);
				send_body($urandom_range(FRAME_MAX, FRAME_MAX + 6));
			end else if (kind < 82) begin
				// frame abandoned by a new start
				send_byte(CH_START);
				send_body($urandom_range(0, 8));
				send_frame($urandom_range(0, 8));
			end else if (kind < 94) begin
				// stray bytes between frames
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom) == CH_START ? CH_END : 8'($urandom));
			end else begin
				send_frame($urandom_range(0, 10));
				wait_drained();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_basics();
		test_length_limits();
		test_back_pressure();
		test_random_frames();
		wait_drained();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/dfr_pkg.sv
rtl/dfr_ram.sv
rtl/delimited_frame_receiver_top.sv
rtl/dfr_checker.sv
test/tb_delimited_frame_receiver_top.sv
